[design/tdch_pkg.sv]
// ============================================================================
// tdch_pkg
// Shared constants, types and helpers for the tile distinct-color histogram.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tdch_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd64;

    localparam int PIX_W       = 8;
    localparam int COLORS      = 256;
    localparam int TILE_LOG    = 3;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int W_SIZE_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_SIZE_W    = $clog2(MAX_HEIGHT + 1);
    localparam int TILE_COLS   = (MAX_WIDTH + 7) / 8;
    localparam int TILE_W      = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

    localparam int BIN_COUNT   = 64;
    localparam int BIN_W       = 6;
    localparam int DC_W        = 7;
    localparam int TC_W        = 15;

    localparam int CHUNK_W     = 64;
    localparam int CHUNKS      = COLORS / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(CHUNKS);
    localparam int CHUNK_BYTES = CHUNK_W / 8;

    typedef struct packed {
        logic accept;
        logic merge;
        logic count_step;
        logic hist_rd;
        logic hist_wr;
        logic dump_rd;
        logic dump_ld;
        logic dump_next;
        logic dump_done;
    } dp_cmd_t;

    typedef struct packed {
        logic tile_done;
        logic image_end;
        logic count_last;
        logic out_taken;
        logic bin_last;
    } dp_status_t;

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[design/tdch_ram.sv]
// ============================================================================
// tdch_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tdch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/tdch_datapath.sv]
// ============================================================================
// tdch_datapath
// Position tracking, tile color maps, popcount, histogram and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tdch_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [tdch_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [tdch_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic [tdch_pkg::PIX_W-1:0]       s_pixel_index,
    input  wire tdch_pkg::dp_cmd_t                cmd,
    output tdch_pkg::dp_status_t                  status,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [tdch_pkg::DC_W-1:0]             m_distinct_colors,
    output logic [tdch_pkg::TC_W-1:0]             m_tile_count,
    output logic                                  m_last_bin
);
    import tdch_pkg::*;

    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [TILE_W-1:0]    tile_reg;
    logic                 tdone_reg;
    logic                 iend_reg;
    logic [TILE_COLS-1:0] map_vld_reg;
    logic [BIN_COUNT-1:0] hist_vld_reg;
    logic [COLORS-1:0]    cnt_map_reg;
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic [DC_W-1:0]      cnt_reg;
    logic [BIN_W-1:0]     bin_reg;
    logic                 m_valid_reg;
    logic [DC_W-1:0]      m_dc_reg;
    logic [TC_W-1:0]      m_tc_reg;
    logic                 m_last_reg;

    logic [W_SIZE_W-1:0]  w_eff;
    logic [H_SIZE_W-1:0]  h_eff;
    logic                 row_end;
    logic                 col_end;
    logic                 tile_done;
    logic [TILE_W-1:0]    tile;
    logic                 cfg_hit;

    logic [COLORS-1:0]    map_rdata;
    logic [COLORS-1:0]    merged;
    logic [DC_W-1:0]      chunk_sum;
    logic [TC_W-1:0]      hist_rdata;
    logic [TC_W-1:0]      hist_old;
    logic [TC_W-1:0]      hist_new;
    logic [BIN_W-1:0]     hist_raddr;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = W_SIZE_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = W_SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = W_SIZE_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = H_SIZE_W'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = H_SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_SIZE_W'(height_reg);
        end
    end

    assign row_end   = (W_SIZE_W'(col_reg) + W_SIZE_W'(1)) >= w_eff;
    assign col_end   = (H_SIZE_W'(row_reg) + H_SIZE_W'(1)) >= h_eff;
    assign tile_done = (row_end || (col_reg[TILE_LOG-1:0] == '1))
                    && (col_end || (row_reg[TILE_LOG-1:0] == '1));
    assign tile      = TILE_W'(col_reg >> TILE_LOG);
    assign cfg_hit   = cfg_wr_en
                    && (cfg_wr_index == REG_IMAGE_WIDTH || cfg_wr_index == REG_IMAGE_HEIGHT);

    assign merged = (map_vld_reg[tile_reg] ? map_rdata : '0) | (COLORS'(1) << pix_reg);

    always_comb begin
        chunk_sum = '0;
        for (int i = 0; i < CHUNK_BYTES; i++) begin
            chunk_sum = chunk_sum + DC_W'(pop8(cnt_map_reg[i*8 +: 8]));
        end
    end

    assign hist_old   = hist_vld_reg[bin_reg] ? hist_rdata : '0;
    assign hist_new   = (&hist_old) ? hist_old : hist_old + TC_W'(1);
    assign hist_raddr = cmd.hist_rd ? BIN_W'(cnt_reg - DC_W'(1)) : bin_reg;

    tdch_ram #(
        .WIDTH (COLORS),
        .DEPTH (TILE_COLS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (cmd.merge && !tdone_reg),
        .waddr (tile_reg),
        .wdata (merged),
        .re    (cmd.accept),
        .raddr (tile),
        .rdata (map_rdata)
    );

    tdch_ram #(
        .WIDTH (TC_W),
        .DEPTH (BIN_COUNT)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (cmd.hist_wr),
        .waddr (bin_reg),
        .wdata (hist_new),
        .re    (cmd.hist_rd || cmd.dump_rd),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= SIZE_RESET;
            height_reg   <= SIZE_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            map_vld_reg  <= '0;
            hist_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_hit) begin
                if (cfg_wr_index == REG_IMAGE_WIDTH) begin
                    width_reg <= cfg_wr_data;
                end else begin
                    height_reg <= cfg_wr_data;
                end
                col_reg      <= '0;
                row_reg      <= '0;
                map_vld_reg  <= '0;
                hist_vld_reg <= '0;
            end else begin
                if (cmd.accept) begin
                    if (!row_end) begin
                        col_reg <= col_reg + COL_W'(1);
                    end else begin
                        col_reg <= '0;
                        row_reg <= col_end ? '0 : row_reg + ROW_W'(1);
                    end
                end
                if (cmd.merge) begin
                    map_vld_reg[tile_reg] <= !tdone_reg;
                end
                if (cmd.hist_wr) begin
                    hist_vld_reg[bin_reg] <= 1'b1;
                end
                if (cmd.dump_done) begin
                    hist_vld_reg <= '0;
                end
            end
            if (cmd.dump_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg   <= s_pixel_index;
            tile_reg  <= tile;
            tdone_reg <= tile_done;
            iend_reg  <= row_end && col_end;
        end
        if (cmd.merge) begin
            cnt_map_reg <= merged;
            chunk_reg   <= '0;
            cnt_reg     <= '0;
        end else if (cmd.count_step) begin
            cnt_map_reg <= cnt_map_reg >> CHUNK_W;
            chunk_reg   <= chunk_reg + CHUNK_IDX_W'(1);
            cnt_reg     <= cnt_reg + chunk_sum;
        end
        if (cmd.hist_rd) begin
            bin_reg <= BIN_W'(cnt_reg - DC_W'(1));
        end else if (cmd.hist_wr) begin
            bin_reg <= '0;
        end else if (cmd.dump_next) begin
            bin_reg <= bin_reg + BIN_W'(1);
        end
        if (cmd.dump_ld) begin
            m_dc_reg   <= DC_W'(bin_reg) + DC_W'(1);
            m_tc_reg   <= hist_old;
            m_last_reg <= (bin_reg == BIN_W'(BIN_COUNT - 1));
        end
    end

    assign status.tile_done  = tdone_reg;
    assign status.image_end  = iend_reg;
    assign status.count_last = (chunk_reg == CHUNK_IDX_W'(CHUNKS - 1));
    assign status.out_taken  = m_valid_reg && m_ready;
    assign status.bin_last   = (bin_reg == BIN_W'(BIN_COUNT - 1));

    assign m_valid           = m_valid_reg;
    assign m_distinct_colors = m_dc_reg;
    assign m_tile_count      = m_tc_reg;
    assign m_last_bin        = m_last_reg;

    a_tile_map_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge && tdone_reg && !cfg_wr_en |=> !map_vld_reg[$past(tile_reg)])
        else $error("tile map still marked valid after its tile closed");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hist_rd |-> (cnt_reg != '0) && (cnt_reg <= DC_W'(BIN_COUNT)))
        else $error("distinct color count out of range");

    a_dump_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dump_done |=> (hist_vld_reg == '0))
        else $error("histogram not cleared after dump");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dump_ld |=> m_valid)
        else $error("loaded bin not presented");

endmodule

`default_nettype wire

[design/tdch_ctrl.sv]
// ============================================================================
// tdch_ctrl
// Sequencer: pixel read-modify-write, tile count, histogram update, bin dump.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tdch_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tdch_pkg::dp_status_t status,
    output tdch_pkg::dp_cmd_t         cmd
);
    import tdch_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_MERGE = 4'd2;
    localparam logic [3:0] ST_COUNT = 4'd3;
    localparam logic [3:0] ST_HRD   = 4'd4;
    localparam logic [3:0] ST_HWR   = 4'd5;
    localparam logic [3:0] ST_DRD   = 4'd6;
    localparam logic [3:0] ST_DLD   = 4'd7;
    localparam logic [3:0] ST_DOUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = status.tile_done ? ST_COUNT : ST_IDLE;
            end
            ST_COUNT: begin
                cmd.count_step = 1'b1;
                if (status.count_last) begin
                    state_next = ST_HRD;
                end
            end
            ST_HRD: begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_HWR;
            end
            ST_HWR: begin
                cmd.hist_wr = 1'b1;
                state_next  = status.image_end ? ST_DRD : ST_IDLE;
            end
            ST_DRD: begin
                cmd.dump_rd = 1'b1;
                state_next  = ST_DLD;
            end
            ST_DLD: begin
                cmd.dump_ld = 1'b1;
                state_next  = ST_DOUT;
            end
            ST_DOUT: begin
                if (status.out_taken) begin
                    if (status.bin_last) begin
                        cmd.dump_done = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.dump_next = 1'b1;
                        state_next    = ST_DRD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/tile_distinct_color_histogram_top.sv]
// ============================================================================
// tile_distinct_color_histogram_top
// Distinct-color histogram over 8x8 tiles of an 8-bit indexed image.
// ============================================================================
// Pixel requests arrive on s_valid/s_ready in raster order, one palette index
// each. Image size is set through cfg_wr_en/cfg_wr_index/cfg_wr_data (index 0
// width, index 1 height); a write restarts the image and clears the histogram.
// A pixel passes through tile map read, merge and write back in one 256-bit
// wide map RAM with one port each way. For a pixel that closes a tile, the
// map is then counted 64 bits per cycle, and the bin is read and written
// back in the histogram RAM.
// After the image's final pixel 64 bin requests follow on m_valid/m_ready,
// bins 1..64, m_last_bin on the last; each is read through the histogram RAM
// read port, and the next only after the receiver takes it. No pixel is
// accepted while the dump runs, and a stalled bin holds in the output
// register. Reset sets both sizes to 64, clears all tile maps, the histogram
// and the position; no clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tile_distinct_color_histogram_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tdch_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [tdch_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tdch_pkg::PIX_W-1:0]     s_pixel_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tdch_pkg::DC_W-1:0]           m_distinct_colors,
    output logic [tdch_pkg::TC_W-1:0]           m_tile_count,
    output logic                                m_last_bin
);
    import tdch_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tdch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tdch_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_index      (cfg_wr_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_pixel_index     (s_pixel_index),
        .cmd               (cmd),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_distinct_colors (m_distinct_colors),
        .m_tile_count      (m_tile_count),
        .m_last_bin        (m_last_bin)
    );

endmodule

`default_nettype wire
